// ----- src/pfr8_pkg.sv -----
// Package for the pixel format to RGBA8 converter: format codes, tables and helpers.
`default_nettype none

package pfr8_pkg;

	typedef enum logic [4:0] {
		FMT_R8          = 5'd0,
		FMT_RG8         = 5'd1,
		FMT_RGBA8       = 5'd2,
		FMT_RGBA8_SRGB  = 5'd3,
		FMT_B5G5R5A1    = 5'd4,
		FMT_B5G6R5      = 5'd5,
		FMT_B4G4R4A4    = 5'd6,
		FMT_R10G10B10A2 = 5'd7,
		FMT_R16         = 5'd8,
		FMT_RG16        = 5'd9,
		FMT_RGBA16      = 5'd10,
		FMT_R16F        = 5'd11,
		FMT_RG16F       = 5'd12,
		FMT_RGBA16F     = 5'd13,
		FMT_R32F        = 5'd14,
		FMT_RG32F       = 5'd15,
		FMT_RGB32F      = 5'd16,
		FMT_RGBA32F     = 5'd17
	} fmt_t;

	typedef logic [7:0] lut4_t [4];
	typedef logic [7:0] lut16_t [16];
	typedef logic [7:0] lut32_t [32];
	typedef logic [7:0] lut64_t [64];

	function automatic lut4_t mk_u2();
		lut4_t t;
		for (int i = 0; i < 4; i++) begin
			t[i] = 8'((i * 255 + 1) / 3);
		end
		return t;
	endfunction

	function automatic lut16_t mk_u4();
		lut16_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = 8'((i * 255 + 7) / 15);
		end
		return t;
	endfunction

	function automatic lut32_t mk_u5();
		lut32_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255 + 15) / 31);
		end
		return t;
	endfunction

	function automatic lut64_t mk_u6();
		lut64_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255 + 31) / 63);
		end
		return t;
	endfunction

	localparam lut4_t  U2_LUT = mk_u2();
	localparam lut16_t U4_LUT = mk_u4();
	localparam lut32_t U5_LUT = mk_u5();
	localparam lut64_t U6_LUT = mk_u6();

	// Division by 2^n - 1 is done as (x + (x >> n) + 1) >> n, exact for these ranges.
	function automatic logic [7:0] unorm10(input logic [9:0] v);
		logic [17:0] x;
		logic [17:0] y;
		x = ({v, 8'b0} - {8'b0, v}) + 18'd511;
		y = x + {10'b0, x[17:10]} + 18'd1;
		return y[17:10];
	endfunction

	function automatic logic [7:0] unorm16(input logic [15:0] v);
		logic [23:0] x;
		logic [23:0] y;
		x = ({v, 8'b0} - {8'b0, v}) + 24'd32767;
		y = x + {16'b0, x[23:16]} + 24'd1;
		return y[23:16];
	endfunction

	// Half subnormals map to zero and half infinities to an infinity; both give 0 later.
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0] e;
		e = h[14:10];
		if (e == 5'd0) begin
			return 32'h0;
		end else if (e == 5'h1F) begin
			return 32'h7F800000;
		end
		return {h[15], {3'b0, e} + 8'd112, h[9:0], 13'b0};
	endfunction

endpackage

`default_nettype wire

// ----- src/pixel_format_to_rgba8_top.sv -----
// Top level of the pixel format to RGBA8 converter.
//
//  channel  | signals                               | transfer when
//  ---------+---------------------------------------+----------------------
//  input    | format_code, pixel_lo, pixel_hi       | start high, busy low
//  result   | chan0..chan3, supported               | done high
//
// One pixel is taken in every cycle; busy is always low.
// The input register holds the transfer, the conversion after it is combinational,
// and the result register holds the converted channels for the outputs.
// Reset clears the valid flags of both stages; the receiver cannot stall.
`default_nettype none

module pixel_format_to_rgba8_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  format_code,
	input  wire logic [63:0] pixel_lo,
	input  wire logic [63:0] pixel_hi,
	output logic             done,
	output logic      [7:0]  chan0,
	output logic      [7:0]  chan1,
	output logic      [7:0]  chan2,
	output logic      [7:0]  chan3,
	output logic             supported
);

	logic               vld_s1;
	pfr8_pkg::fmt_t     fmt_s1;
	logic [63:0]        lo_s1;
	logic [63:0]        hi_s1;
	logic               vld_s2;
	logic [7:0]         c_s2 [4];
	logic               ok_s2;

	logic [15:0]        h [4];
	logic [31:0]        w [4];
	logic [31:0]        fw [4];
	logic [7:0]         fo [4];
	logic [7:0]         u16 [4];
	logic [7:0]         u10 [4];
	logic [7:0]         c [4];
	logic               ok;
	logic               half_fmt;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fmt_s1 <= pfr8_pkg::fmt_t'(format_code);
			lo_s1  <= pixel_lo;
			hi_s1  <= pixel_hi;
		end
		if (vld_s1) begin
			c_s2  <= c;
			ok_s2 <= ok;
		end
	end

	assign w[0] = lo_s1[31:0];
	assign w[1] = lo_s1[63:32];
	assign w[2] = hi_s1[31:0];
	assign w[3] = hi_s1[63:32];

	assign half_fmt = (fmt_s1 == pfr8_pkg::FMT_R16F) || (fmt_s1 == pfr8_pkg::FMT_RG16F) ||
		(fmt_s1 == pfr8_pkg::FMT_RGBA16F);

	for (genvar i = 0; i < 4; i++) begin : g_lane
		assign h[i]   = lo_s1[16*i +: 16];
		assign fw[i]  = half_fmt ? pfr8_pkg::half_to_single(h[i]) : w[i];
		assign u16[i] = pfr8_pkg::unorm16(h[i]);
		assign u10[i] = (i == 3) ? pfr8_pkg::U2_LUT[lo_s1[31:30]] :
			pfr8_pkg::unorm10(lo_s1[10*i +: 10]);
		pfr8_float8 u_float8 (
			.bits(fw[i]),
			.res (fo[i])
		);
	end

	always_comb begin
		c[0] = 8'd0;
		c[1] = 8'd0;
		c[2] = 8'd0;
		c[3] = 8'd255;
		ok   = 1'b1;
		case (fmt_s1)
			pfr8_pkg::FMT_R8: begin
				c[0] = lo_s1[7:0];
				c[1] = lo_s1[7:0];
				c[2] = lo_s1[7:0];
			end
			pfr8_pkg::FMT_RG8: begin
				c[0] = lo_s1[7:0];
				c[1] = lo_s1[15:8];
			end
			pfr8_pkg::FMT_RGBA8, pfr8_pkg::FMT_RGBA8_SRGB: begin
				c[0] = lo_s1[7:0];
				c[1] = lo_s1[15:8];
				c[2] = lo_s1[23:16];
				c[3] = lo_s1[31:24];
			end
			pfr8_pkg::FMT_B5G5R5A1: begin
				c[0] = pfr8_pkg::U5_LUT[lo_s1[14:10]];
				c[1] = pfr8_pkg::U5_LUT[lo_s1[9:5]];
				c[2] = pfr8_pkg::U5_LUT[lo_s1[4:0]];
				c[3] = lo_s1[15] ? 8'd255 : 8'd0;
			end
			pfr8_pkg::FMT_B5G6R5: begin
				c[0] = pfr8_pkg::U5_LUT[lo_s1[15:11]];
				c[1] = pfr8_pkg::U6_LUT[lo_s1[10:5]];
				c[2] = pfr8_pkg::U5_LUT[lo_s1[4:0]];
			end
			pfr8_pkg::FMT_B4G4R4A4: begin
				c[0] = pfr8_pkg::U4_LUT[lo_s1[11:8]];
				c[1] = pfr8_pkg::U4_LUT[lo_s1[7:4]];
				c[2] = pfr8_pkg::U4_LUT[lo_s1[3:0]];
				c[3] = pfr8_pkg::U4_LUT[lo_s1[15:12]];
			end
			pfr8_pkg::FMT_R10G10B10A2: begin
				c = u10;
			end
			pfr8_pkg::FMT_R16: begin
				c[0] = u16[0];
				c[1] = u16[0];
				c[2] = u16[0];
			end
			pfr8_pkg::FMT_RG16: begin
				c[0] = u16[0];
				c[1] = u16[1];
			end
			pfr8_pkg::FMT_RGBA16: begin
				c = u16;
			end
			pfr8_pkg::FMT_R16F, pfr8_pkg::FMT_R32F: begin
				c[0] = fo[0];
				c[1] = fo[0];
				c[2] = fo[0];
			end
			pfr8_pkg::FMT_RG16F, pfr8_pkg::FMT_RG32F: begin
				c[0] = fo[0];
				c[1] = fo[1];
			end
			pfr8_pkg::FMT_RGB32F: begin
				c[0] = fo[0];
				c[1] = fo[1];
				c[2] = fo[2];
			end
			pfr8_pkg::FMT_RGBA16F, pfr8_pkg::FMT_RGBA32F: begin
				c = fo;
			end
			default: begin
				c[3] = 8'd0;
				ok   = 1'b0;
			end
		endcase
	end

	assign done      = vld_s2;
	assign chan0     = c_s2[0];
	assign chan1     = c_s2[1];
	assign chan2     = c_s2[2];
	assign chan3     = c_s2[3];
	assign supported = ok_s2;

endmodule

`default_nettype wire

// ----- src/pfr8_float8.sv -----
// Converts one binary32 value to an 8-bit unorm channel with clamping and rounding.
`default_nettype none

module pfr8_float8 (
	input  wire logic [31:0] bits,
	output logic      [7:0]  res
);

	logic [7:0]  exp_in;
	logic [7:0]  e;
	logic [23:0] m24;
	logic [31:0] p;
	logic [23:0] keep;
	logic        inc;
	logic [24:0] keep_r;
	logic [33:0] pr;
	logic [7:0]  s;
	logic [34:0] sum;
	logic [34:0] shifted;

	always_comb begin
		exp_in = bits[30:23];
		if (exp_in > 8'd127 || (exp_in == 8'd127 && bits[22:0] != 23'd0)) begin
			m24 = 24'h800000;
			e   = 8'd127;
		end else begin
			m24 = {1'b1, bits[22:0]};
			e   = exp_in;
		end
		p = {m24, 8'b0} - {8'b0, m24};
		if (p[31]) begin
			keep = p[31:8];
			inc  = p[7] & ((|p[6:0]) | p[8]);
		end else begin
			keep = p[30:7];
			inc  = p[6] & ((|p[5:0]) | p[7]);
		end
		keep_r = {1'b0, keep} + {24'b0, inc};
		pr = p[31] ? {1'b0, keep_r, 8'b0} : {2'b0, keep_r, 7'b0};
		s = 8'd150 - e;
		sum = {1'b0, pr} + (35'd1 << (s[5:0] - 6'd1));
		shifted = sum >> s[5:0];
		if (exp_in == 8'hFF || exp_in == 8'd0 || bits[31] || s > 8'd33) begin
			res = 8'd0;
		end else begin
			res = shifted[7:0];
		end
	end

endmodule

`default_nettype wire
